// ===== rtl/gbfd_pkg.sv =====
`timescale 1ns / 1ps

package gbfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 9;
  localparam int unsigned CntW  = PosW + 1;

  localparam logic [ByteW-1:0] CH_AT = 8'h40;
  localparam logic [ByteW-1:0] CH_C  = 8'h43;
  localparam logic [ByteW-1:0] CH_J  = 8'h6A;
  localparam logic [ByteW-1:0] CH_CR = 8'h0D;
  localparam logic [ByteW-1:0] CH_LF = 8'h0A;

  localparam logic [PosW-1:0] POS_ID_FIRST  = 9'd2;
  localparam logic [PosW-1:0] POS_ID_SECOND = 9'd3;

  localparam logic [PosW-1:0] OVERFLOW_LIMIT_RST = 9'd300;
  localparam logic [PosW-1:0] LONG_ID_CUTOFF_RST = 9'd290;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_OVERFLOW_LIMIT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_ID_CUTOFF = 1'b1;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_AT1  = 4'b0010,
    PH_BODY = 4'b0100,
    PH_CR   = 4'b1000
  } phase_e;

endpackage

// ===== rtl/gbfd_if.sv =====
`timescale 1ns / 1ps

// Byte stream into the deframer.
interface gbfd_in_if;
  logic                     valid;
  logic                     ready;
  logic [gbfd_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Annotated byte stream out of the deframer.
interface gbfd_out_if;
  logic                      valid;
  logic                      ready;
  logic [gbfd_pkg::ByteW-1:0] out_byte;
  logic [gbfd_pkg::PosW-1:0]  byte_position;
  logic                      in_frame;
  logic                      frame_end;
  logic                      overflow;

  modport source (output valid, output out_byte, output byte_position, output in_frame,
                  output frame_end, output overflow, input ready);
  modport sink   (input valid, input out_byte, input byte_position, input in_frame,
                  input frame_end, input overflow, output ready);
endinterface

// ===== rtl/gps_binary_frame_deframer.sv =====
`timescale 1ns / 1ps

// Deframer for binary receiver messages of the form '@' '@' body CR LF. Every
// received byte comes back out once, in order, tagged with its position in
// the current frame and with in_frame, frame_end and overflow flags. The block
// takes one byte per cycle unless stalled, and the tagged byte is offered in
// the cycle after its transfer; the rate is set by the single parse step that
// updates the phase, count and id registers for each byte. An output register
// decouples the two sides: a new byte is taken whenever the output register is
// empty or its contents leave in the same cycle. For message id 'Cj' a CR LF
// before long_id_cutoff bytes counts as body data. A frame whose count passes
// overflow_limit is dropped and hunting restarts. Write both limits via the
// configuration port while the stream is idle; the block does not check it.
module gps_binary_frame_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gbfd_in_if.sink                       rx,
  gbfd_out_if.source                    tx,
  input  logic                          cfg_we_i,
  input  logic [gbfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gbfd_pkg::PosW-1:0]     cfg_wdata_i
);

  // Configuration registers.
  logic [gbfd_pkg::PosW-1:0] ovf_limit_q, cutoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_limit_q <= gbfd_pkg::OVERFLOW_LIMIT_RST;
      cutoff_q    <= gbfd_pkg::LONG_ID_CUTOFF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gbfd_pkg::CFG_OVERFLOW_LIMIT: ovf_limit_q <= cfg_wdata_i;
        gbfd_pkg::CFG_LONG_ID_CUTOFF: cutoff_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Parser state.
  gbfd_pkg::phase_e           phase_q, phase_d;
  logic [gbfd_pkg::PosW-1:0]  count_q, count_d;
  logic [gbfd_pkg::ByteW-1:0] id_first_q, id_first_d;
  logic [gbfd_pkg::ByteW-1:0] id_second_q, id_second_d;

  // Output register.
  logic                       out_valid_q;
  logic [gbfd_pkg::ByteW-1:0] out_byte_q;
  logic [gbfd_pkg::PosW-1:0]  out_pos_q;
  logic                       out_inf_q, out_fend_q, out_ovf_q;

  logic                       in_xfer;
  logic [gbfd_pkg::ByteW-1:0] b;
  gbfd_pkg::phase_e           next_ph;
  logic                       hunt_next;
  logic                       got_lf;
  logic [gbfd_pkg::CntW-1:0]  cnt;
  logic                       inf, fend, ovf;
  logic                       long_id;

  // The output register is free when empty or when it drains this cycle.
  assign rx.ready = !out_valid_q || tx.ready;
  assign in_xfer  = rx.valid && rx.ready;
  assign b        = rx.rx_byte;
  assign cnt      = {1'b0, count_q} + gbfd_pkg::CntW'(1);

  // Header and trailer recognition: where this byte takes the phase before
  // the length checks are applied.
  always_comb begin
    got_lf    = 1'b0;
    hunt_next = 1'b0;
    next_ph   = gbfd_pkg::PH_HUNT;
    unique case (phase_q)
      gbfd_pkg::PH_AT1: begin
        if (b == gbfd_pkg::CH_AT) begin
          next_ph = gbfd_pkg::PH_BODY;
        end else begin
          hunt_next = 1'b1;
        end
      end
      gbfd_pkg::PH_BODY: begin
        next_ph = (b == gbfd_pkg::CH_CR) ? gbfd_pkg::PH_CR : gbfd_pkg::PH_BODY;
      end
      gbfd_pkg::PH_CR: begin
        if (b == gbfd_pkg::CH_LF) begin
          next_ph = gbfd_pkg::PH_BODY;
          got_lf  = 1'b1;
        end else if (b == gbfd_pkg::CH_CR) begin
          next_ph = gbfd_pkg::PH_CR;
        end else begin
          next_ph = gbfd_pkg::PH_BODY;
        end
      end
      default: begin
        // Hunting, and any code that should never be seen.
        if (b == gbfd_pkg::CH_AT) begin
          next_ph = gbfd_pkg::PH_AT1;
        end else begin
          hunt_next = 1'b1;
        end
      end
    endcase
  end

  // The 'Cj' serial-number message may carry CR LF inside its body, so its
  // end is only honored once the frame has reached the cutoff length.
  assign long_id = (id_first_q == gbfd_pkg::CH_C) && (id_second_q == gbfd_pkg::CH_J) &&
                   (cnt < {1'b0, cutoff_q});

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    id_first_d  = id_first_q;
    id_second_d = id_second_q;
    inf         = 1'b0;
    fend        = 1'b0;
    ovf         = 1'b0;
    if (hunt_next) begin
      phase_d = gbfd_pkg::PH_HUNT;
      count_d = '0;
    end else begin
      inf = 1'b1;
      if (count_q == gbfd_pkg::POS_ID_FIRST) begin
        id_first_d = b;
      end else if (count_q == gbfd_pkg::POS_ID_SECOND) begin
        id_second_d = b;
      end
      if (got_lf) begin
        if (long_id) begin
          phase_d = gbfd_pkg::PH_BODY;
          count_d = cnt[gbfd_pkg::PosW-1:0];
        end else begin
          fend    = 1'b1;
          phase_d = gbfd_pkg::PH_HUNT;
          count_d = '0;
        end
      end else if (cnt > {1'b0, ovf_limit_q}) begin
        // Also covers a count that would pass the width of the counter.
        ovf     = 1'b1;
        phase_d = gbfd_pkg::PH_HUNT;
        count_d = '0;
      end else begin
        phase_d = next_ph;
        count_d = cnt[gbfd_pkg::PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= gbfd_pkg::PH_HUNT;
      count_q     <= '0;
      id_first_q  <= '0;
      id_second_q <= '0;
    end else if (in_xfer) begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      id_first_q  <= id_first_d;
      id_second_q <= id_second_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rx.ready) begin
      out_valid_q <= rx.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_byte_q <= b;
      out_pos_q  <= count_q;
      out_inf_q  <= inf;
      out_fend_q <= fend;
      out_ovf_q  <= ovf;
    end
  end

  assign tx.valid         = out_valid_q;
  assign tx.out_byte      = out_byte_q;
  assign tx.byte_position = out_pos_q;
  assign tx.in_frame      = out_inf_q;
  assign tx.frame_end     = out_fend_q;
  assign tx.overflow      = out_ovf_q;

endmodule

// ===== rtl/gbfd_checker.sv =====
`timescale 1ns / 1ps

module gbfd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [gbfd_pkg::ByteW-1:0]  out_byte_i,
  input logic [gbfd_pkg::PosW-1:0]   byte_position_i,
  input logic                        in_frame_i,
  input logic                        frame_end_i,
  input logic                        overflow_i
);

  // A stalled result keeps its byte, position and frame-end flag.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
      $stable(byte_position_i) && $stable(frame_end_i))
    else $error("stalled result changed");

  // A frame end is always an in-frame LF.
  a_fend_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i |-> in_frame_i && out_byte_i == gbfd_pkg::CH_LF)
    else $error("frame end on a byte that is not an in-frame LF");

  // Overflow and frame end never come together, and overflow is in frame.
  a_ovf_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && overflow_i |-> in_frame_i && !frame_end_i)
    else $error("overflow flag combined with frame end or outside a frame");

  // Bytes outside a frame are seen while hunting, at position zero, or are
  // the byte after a lone '@' that failed to complete the header.
  a_hunt_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !in_frame_i |-> byte_position_i == '0 ||
      (byte_position_i == gbfd_pkg::PosW'(1) && out_byte_i != gbfd_pkg::CH_AT))
    else $error("byte outside a frame at an unexpected position");

endmodule

bind gps_binary_frame_deframer gbfd_checker u_gbfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (tx.valid),
  .out_ready_i     (tx.ready),
  .out_byte_i      (tx.out_byte),
  .byte_position_i (tx.byte_position),
  .in_frame_i      (tx.in_frame),
  .frame_end_i     (tx.frame_end),
  .overflow_i      (tx.overflow)
);

// ===== tb/sv/gps_binary_frame_deframer_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the binary frame deframer. Bytes go in through the
// rx channel, and each tagged byte that comes back on the tx channel is
// checked against a predictor that runs on every accepted input transfer.
module gps_binary_frame_deframer_tb;
  import gbfd_pkg::*;

  // One tagged byte as the block hands it out.
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [PosW-1:0]  byte_position;
    logic             in_frame;
    logic             frame_end;
    logic             overflow;
  } annotated_byte_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [PosW-1:0]     cfg_wdata_i;

  gbfd_in_if  rx_if ();
  gbfd_out_if tx_if ();

  gps_binary_frame_deframer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx          (rx_if),
    .tx          (tx_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predictor state: the parse phase, the frame byte count, the two id bytes
  // and the bench's own copy of both limit registers.
  phase_e          cur_phase;
  logic [PosW-1:0] frame_count;
  logic [ByteW-1:0] msg_id_hi;
  logic [ByteW-1:0] msg_id_lo;
  logic [PosW-1:0] lim_overflow;
  logic [PosW-1:0] lim_cutoff;

  // Tagged bytes that are predicted but have not come out yet, oldest first.
  annotated_byte_t pending_tags[$];

  int unsigned bad_count;
  int unsigned sent_total;
  int unsigned stall_left;
  // While calm is set, neither side inserts gaps or stalls.
  bit          calm;

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  // Random gap length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end else if (r < 99) begin
      return $urandom_range(4, 12);
    end else begin
      return $urandom_range(20, 60);
    end
  endfunction

  // Limit values for a random phase: the two extremes, small values that
  // make overflow and the long-id cutoff bite often, and the full range.
  function automatic logic [PosW-1:0] pick_limit();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end else if (r < 7) begin
      return PosW'($urandom_range(1, 48));
    end else begin
      return PosW'($urandom_range(0, 511));
    end
  endfunction

  // Advances the predictor by one received byte and returns the tagged byte
  // that the block must produce for it.
  function automatic annotated_byte_t deframe_byte(input logic [ByteW-1:0] b);
    annotated_byte_t r;
    phase_e          nxt;
    logic [PosW:0]   cnt;
    logic            got_lf;
    r = '0;
    got_lf = 1'b0;
    r.out_byte = b;
    r.byte_position = frame_count;
    case (cur_phase)
      PH_AT1: nxt = (b == CH_AT) ? PH_BODY : PH_HUNT;
      PH_BODY: nxt = (b == CH_CR) ? PH_CR : PH_BODY;
      PH_CR: begin
        // A second CR keeps us waiting for the LF; anything else is body.
        if (b == CH_LF) begin
          nxt = PH_BODY;
          got_lf = 1'b1;
        end else if (b == CH_CR) begin
          nxt = PH_CR;
        end else begin
          nxt = PH_BODY;
        end
      end
      default: nxt = (b == CH_AT) ? PH_AT1 : PH_HUNT;
    endcase
    if (nxt == PH_HUNT) begin
      // Hunting, or a failed second '@': the byte is not part of a frame.
      cur_phase = PH_HUNT;
      frame_count = '0;
    end else begin
      r.in_frame = 1'b1;
      if (frame_count == POS_ID_FIRST) begin
        msg_id_hi = b;
      end else if (frame_count == POS_ID_SECOND) begin
        msg_id_lo = b;
      end
      // One bit wider than the position, so that a count of 512 is seen as
      // exceeding every limit instead of wrapping.
      cnt = {1'b0, frame_count} + 1'b1;
      if (got_lf) begin
        if (msg_id_hi == CH_C && msg_id_lo == CH_J && cnt < {1'b0, lim_cutoff}) begin
          // A short 'Cj' message treats CR LF as data and keeps gathering.
          cur_phase = PH_BODY;
          frame_count = cnt[PosW-1:0];
        end else begin
          r.frame_end = 1'b1;
          cur_phase = PH_HUNT;
          frame_count = '0;
        end
      end else if (cnt > {1'b0, lim_overflow}) begin
        r.overflow = 1'b1;
        cur_phase = PH_HUNT;
        frame_count = '0;
      end else begin
        cur_phase = nxt;
        frame_count = cnt[PosW-1:0];
      end
    end
    return r;
  endfunction

  // Offers one byte after a random gap and waits for its transfer. The
  // prediction is made at the very edge at which the byte is taken.
  task automatic push_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    pending_tags.push_back(deframe_byte(b));
    sent_total++;
  endtask

  task automatic push_header(input logic [ByteW-1:0] id1, input logic [ByteW-1:0] id2);
    push_byte(CH_AT);
    push_byte(CH_AT);
    push_byte(id1);
    push_byte(id2);
  endtask

  // Stops sending and waits until every predicted byte has come out, then
  // lets the output register settle.
  task automatic wait_stream_idle();
    rx_if.valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Both limit registers are written back to back on an idle stream. The
  // predictor copy changes only once the writes are done.
  task automatic write_limits(input logic [PosW-1:0] ovl, input logic [PosW-1:0] cut);
    wait_stream_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_OVERFLOW_LIMIT;
    cfg_wdata_i <= ovl;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_LONG_ID_CUTOFF;
    cfg_wdata_i <= cut;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    lim_overflow = ovl;
    lim_cutoff   = cut;
  endtask

  // A well-formed frame under the reset limits, with the byte extremes in
  // the body and a doubled CR before the closing LF.
  task automatic test_basic_frame();
    push_header(8'h58, 8'h59);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_CR);
    push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  // A stray byte while hunting, then an '@' whose partner never arrives.
  task automatic test_failed_header();
    push_byte(8'hFF);
    push_byte(CH_AT);
    push_byte(8'h5A);
  endtask

  // With a cutoff of 8 the first CR LF of a 'Cj' message is only data; the
  // second one comes late enough to close the frame. The sender then holds
  // off until the block has drained.
  task automatic test_deferred_id_end();
    write_limits(OVERFLOW_LIMIT_RST, 9'd8);
    push_header(CH_C, CH_J);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte(8'h61);
    push_byte(CH_CR);
    push_byte(CH_LF);
    wait_stream_idle();
  endtask

  // The fifth byte of a frame pushes the count past a limit of 4.
  task automatic test_overflow();
    write_limits(9'd4, LONG_ID_CUTOFF_RST);
    push_header(8'h61, 8'h62);
    push_byte(8'h63);
  endtask

  // The register extremes: a zero overflow limit drops every '@', a zero
  // cutoff lets a short 'Cj' frame end, and at 511 the longest 'Cj' frame
  // ends exactly at the cutoff while a plain frame overflows at count 512.
  task automatic test_limit_extremes();
    logic [ByteW-1:0] b;
    write_limits(9'd0, 9'd0);
    push_byte(CH_AT);
    push_byte(CH_AT);
    write_limits(9'd511, 9'd0);
    push_header(CH_C, CH_J);
    push_byte(CH_CR);
    push_byte(CH_LF);
    write_limits(9'd511, 9'd511);
    push_header(CH_C, CH_J);
    for (int p = 4; p < 509; p++) begin
      push_byte(8'($urandom_range(0, 255)));
    end
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_header(8'h41, 8'h42);
    for (int p = 4; p < 512; p++) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_CR) begin
        b = 8'h00;
      end
      push_byte(b);
    end
  endtask

  // One random chunk of stream: mostly complete frames with random ids and
  // bodies, the rest broken frames and plain line noise.
  task automatic push_random_chunk();
    int unsigned kind;
    int unsigned len;
    logic [ByteW-1:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      if ($urandom_range(0, 9) < 4) begin
        push_header(CH_C, CH_J);
      end else begin
        push_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom_range(0, 255));
        // Keep stray CRs rare so that most frames reach their own trailer.
        if (b == CH_CR && $urandom_range(0, 9) != 0) begin
          b = 8'h20;
        end
        push_byte(b);
      end
      if ($urandom_range(0, 7) == 0) begin
        push_byte(CH_CR);
      end
      push_byte(CH_CR);
      push_byte(CH_LF);
    end else if (kind < 78) begin
      push_byte(CH_AT);
      b = 8'($urandom_range(0, 255));
      if (b == CH_AT) begin
        b = 8'h00;
      end
      push_byte(b);
    end else if (kind < 85) begin
      // A header with a broken trailer: CR followed by something not LF,
      // or a frame that just stops and runs into whatever follows.
      push_byte(CH_AT);
      push_byte(CH_AT);
      len = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
        push_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) == 0) begin
        push_byte(CH_CR);
        push_byte(8'($urandom_range(0, 255)));
      end
    end else begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        push_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Random phases, each under freshly chosen limits, until the whole run has
  // sent about 1650 bytes. Some phases run with no gaps and no stalls at all,
  // and now and then the sender pauses until the block is empty.
  task automatic test_random_stream();
    int unsigned phase_stop;
    while (sent_total < 1650) begin
      write_limits(pick_limit(), pick_limit());
      calm = ($urandom_range(0, 3) == 0);
      phase_stop = sent_total + $urandom_range(100, 180);
      if (phase_stop > 1650) begin
        phase_stop = 1650;
      end
      while (sent_total < phase_stop) begin
        push_random_chunk();
        if ($urandom_range(0, 49) == 0) begin
          wait_stream_idle();
        end
      end
    end
    calm = 1'b0;
  endtask

  // The receiver stalls at random, in the same mix of short and long gaps.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      tx_if.ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left   <= pick_gap();
      tx_if.ready  <= 1'b0;
    end else begin
      tx_if.ready  <= 1'b1;
    end
  end

  // Every output transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    annotated_byte_t got;
    annotated_byte_t want;
    if (rst_ni && tx_if.valid && tx_if.ready) begin
      got.out_byte      = tx_if.out_byte;
      got.byte_position = tx_if.byte_position;
      got.in_frame      = tx_if.in_frame;
      got.frame_end     = tx_if.frame_end;
      got.overflow      = tx_if.overflow;
      if (pending_tags.size() == 0) begin
        if (bad_count < 10) begin
          $display("unexpected byte %h pos %0d", got.out_byte, got.byte_position);
        end
        bad_count++;
      end else begin
        want = pending_tags.pop_front();
        if (got.out_byte !== want.out_byte || got.byte_position !== want.byte_position ||
            got.in_frame !== want.in_frame || got.frame_end !== want.frame_end ||
            got.overflow !== want.overflow) begin
          if (bad_count < 10) begin
            $display("mismatch: exp byte %h pos %0d in/end/ovf %b%b%b",
                     want.out_byte, want.byte_position, want.in_frame,
                     want.frame_end, want.overflow);
            $display("          got byte %h pos %0d in/end/ovf %b%b%b",
                     got.out_byte, got.byte_position, got.in_frame,
                     got.frame_end, got.overflow);
          end
          bad_count++;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_OVERFLOW_LIMIT;
    cfg_wdata_i   = '0;
    cur_phase     = PH_HUNT;
    frame_count   = '0;
    msg_id_hi     = '0;
    msg_id_lo     = '0;
    lim_overflow  = OVERFLOW_LIMIT_RST;
    lim_cutoff    = LONG_ID_CUTOFF_RST;
    sent_total    = 0;
    calm          = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_frame();
    test_failed_header();
    test_deferred_id_end();
    test_overflow();
    test_limit_extremes();
    test_random_stream();

    // Drain everything that is still in flight, then keep watching the output
    // register in case a stray byte shows up.
    wait_stream_idle();
    repeat (8) @(posedge clk_i);
    if (bad_count == 0 && pending_tags.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== gps_binary_frame_deframer.f =====
rtl/gbfd_pkg.sv
rtl/gbfd_if.sv
rtl/gps_binary_frame_deframer.sv
rtl/gbfd_checker.sv
tb/sv/gps_binary_frame_deframer_tb.sv
